### src/time_value_to_date_fields_assert.svh
// Assertion macros shared by the time value to date fields RTL.
`ifndef TIME_VALUE_TO_DATE_FIELDS_ASSERT_SVH
`define TIME_VALUE_TO_DATE_FIELDS_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define TVDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, checked outside reset.
`define TVDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tvdf_pkg.sv
// Package with constants, the pipeline word and the per-stage arithmetic.
package tvdf_pkg;

  localparam int NSTG = 27;

  localparam logic [55:0] TIME_LIMIT = 56'd8640000000000000;
  localparam logic [55:0] TIME_SPAN  = 56'd17280000000000000;
  localparam logic [55:0] DAY_MS     = 56'd86400000;
  localparam logic [29:0] ERA_DAYS   = 30'd146097;
  localparam logic [27:0] ZZ_OFS     = 28'd2987368;
  localparam logic [27:0] HOUR_MS    = 28'd3600000;
  localparam logic [27:0] MIN_MS     = 28'd60000;
  localparam logic [27:0] SEC_MS     = 28'd1000;
  localparam logic [17:0] CENT_DAYS  = 18'd36524;
  localparam logic [17:0] QUAD_DAYS  = 18'd1461;
  localparam logic [17:0] YEAR_DAYS  = 18'd365;
  localparam int          YEAR_BIAS  = 280000;
  localparam logic [8:0]  JAN_MARCH  = 9'd306;
  localparam logic [8:0]  FEB_END    = 9'd59;
  localparam logic [8:0]  MONTH_BEGIN [0:11] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                                 9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
                                                 9'd334};

  typedef struct packed {
    logic        ok;
    logic [54:0] rem_d;
    logic [27:0] qday;
    logic [26:0] rem_t;
    logic [5:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [27:0] rem_e;
    logic [11:0] era;
    logic [2:0]  wday;
    logic [2:0]  cent;
    logic [4:0]  quad;
    logic [2:0]  yrq;
    logic [8:0]  doy_mar;
    logic        leap;
    logic [19:0] year;
    logic [8:0]  doy;
    logic [3:0]  month;
    logic [4:0]  mday;
  } tvdf_work_t;

  function automatic logic [2:0] mod7(input logic [29:0] v);
    logic [6:0] s;
    logic [3:0] f;
    logic [3:0] g;
    s = '0;
    for (int i = 0; i < 10; i++) s = s + 7'(v[3*i +: 3]);
    f = 4'(s[6:3]) + 4'(s[2:0]);
    g = 4'(f[3]) + 4'(f[2:0]);
    if (g >= 4'd7) g = g - 4'd7;
    return g[2:0];
  endfunction

  function automatic logic [8:0] month_start(input int unsigned m, input logic leap);
    return MONTH_BEGIN[m[3:0]] + ((m >= 2) ? 9'(leap) : 9'd0);
  endfunction

  function automatic tvdf_work_t tvdf_entry(input logic signed [53:0] t, input logic tv);
    tvdf_work_t r;
    logic signed [55:0] us;
    r = '0;
    us = 56'(t) + $signed(TIME_LIMIT);
    r.ok = tv && !us[55] && ($unsigned(us) <= TIME_SPAN);
    r.rem_d = r.ok ? us[54:0] : '0;
    return r;
  endfunction

  function automatic tvdf_work_t tvdf_stage(input int unsigned s, input tvdf_work_t w);
    tvdf_work_t r;
    int unsigned bi;
    int unsigned k;
    int yr;
    logic [55:0] dd;
    logic [27:0] dt;
    logic [29:0] de;
    logic [8:0]  yoe;
    logic        jf;
    r = w;
    if (s >= 1 && s <= 14) begin
      for (int j = 0; j < 2; j++) begin
        bi = 29 - 2 * s - j;
        dd = DAY_MS << bi;
        if ({1'b0, r.rem_d} >= dd) begin
          r.rem_d = r.rem_d - dd[54:0];
          r.qday[bi[4:0]] = 1'b1;
        end
      end
    end else if (s == 15) begin
      r.rem_e = r.qday + ZZ_OFS;
      r.wday = mod7(30'(r.qday) + 30'd2);
      r.rem_t = r.rem_d[26:0];
    end else if (s >= 16 && s <= 21) begin
      k = s - 16;
      for (int j = 0; j < 2; j++) begin
        bi = 11 - 2 * k - j;
        de = ERA_DAYS << bi;
        if ({2'b0, r.rem_e} >= de) begin
          r.rem_e = r.rem_e - de[27:0];
          r.era[bi[3:0]] = 1'b1;
        end
      end
      for (int j = 0; j < 3; j++) begin
        bi = 5 - 3 * (k % 2) - j;
        case (k / 2)
          0: dt = HOUR_MS << bi;
          1: dt = MIN_MS << bi;
          default: dt = SEC_MS << bi;
        endcase
        if ({1'b0, r.rem_t} >= dt) begin
          r.rem_t = r.rem_t - dt[26:0];
          case (k / 2)
            0: r.hour[bi[2:0]] = 1'b1;
            1: r.minute[bi[2:0]] = 1'b1;
            default: r.second[bi[2:0]] = 1'b1;
          endcase
        end
      end
    end else if (s == 22) begin
      for (int j = 0; j < 3; j++) begin
        bi = 2 - j;
        de = 30'(CENT_DAYS) << bi;
        if ({2'b0, r.rem_e} >= de) begin
          r.rem_e = r.rem_e - de[27:0];
          r.cent[bi[1:0]] = 1'b1;
        end
      end
      if (r.cent == 3'd4) begin
        r.cent = 3'd3;
        r.rem_e = r.rem_e + 28'(CENT_DAYS);
      end
    end else if (s == 23) begin
      for (int j = 0; j < 5; j++) begin
        bi = 4 - j;
        de = 30'(QUAD_DAYS) << bi;
        if ({2'b0, r.rem_e} >= de) begin
          r.rem_e = r.rem_e - de[27:0];
          r.quad[bi[2:0]] = 1'b1;
        end
      end
    end else if (s == 24) begin
      for (int j = 0; j < 3; j++) begin
        bi = 2 - j;
        de = 30'(YEAR_DAYS) << bi;
        if ({2'b0, r.rem_e} >= de) begin
          r.rem_e = r.rem_e - de[27:0];
          r.yrq[bi[1:0]] = 1'b1;
        end
      end
      if (r.yrq == 3'd4) begin
        r.yrq = 3'd3;
        r.rem_e = r.rem_e + 28'(YEAR_DAYS);
      end
      r.doy_mar = r.rem_e[8:0];
      r.leap = (r.yrq == 3'd3) && ((r.quad != 5'd24) || (r.cent == 3'd3));
    end else if (s == 25) begin
      yoe = 9'(r.cent) * 9'd100 + 9'({r.quad, 2'b00}) + 9'(r.yrq);
      jf = (r.doy_mar >= JAN_MARCH);
      if (!jf) r.leap = (r.yrq == 3'd0) && ((r.quad != 5'd0) || (r.cent == 3'd0));
      yr = int'(r.era) * 400 + int'(yoe) + int'(jf) - YEAR_BIAS;
      r.year = yr[19:0];
      r.doy = jf ? (r.doy_mar - JAN_MARCH) : (r.doy_mar + FEB_END + 9'(r.leap));
    end else if (s == 26) begin
      r.month = '0;
      for (int m = 1; m < 12; m++) begin
        if (r.doy >= month_start(m, r.leap)) r.month = 4'(m);
      end
      r.mday = 5'(r.doy - month_start(int'(r.month), r.leap) + 9'd1);
    end
    return r;
  endfunction

endpackage

### src/tvdf_pipe_reg.sv
// One pipeline register stage with a valid bit and local ready.
module tvdf_pipe_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  tvdf_pkg::tvdf_work_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output tvdf_pkg::tvdf_work_t dn_data
);
  import tvdf_pkg::*;

  logic       full;
  tvdf_work_t data;

  assign up_ready = !full || dn_ready;
  assign dn_valid = full;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (up_ready) begin
      full <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_data;
    end
  end
endmodule

### src/time_value_to_date_fields.sv
// Top level: pipelined split of a millisecond time value into civil date fields.
//   channel | handshake            | payload
//   in      | in_valid / in_ready   | time_ms, time_valid
//   out     | out_valid / out_ready | year .. millisecond, fields_valid
// The long divisions by the day and era lengths set the depth of 27 register stages.
// One item is accepted per cycle unless an output stall has backed up to the input.
// Reset empties every stage; no result is in flight afterwards.
// A stall at the output holds the full stages; empty stages keep filling from the input.
module time_value_to_date_fields (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [53:0] time_ms,
  input  logic               time_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] year,
  output logic [3:0]         month,
  output logic [4:0]         day_of_month,
  output logic [8:0]         day_of_year,
  output logic               leap_year,
  output logic [2:0]         weekday,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second,
  output logic [9:0]         millisecond,
  output logic               fields_valid
);
  import tvdf_pkg::*;
  `include "time_value_to_date_fields_assert.svh"

  logic       stg_v   [0:NSTG-1];
  logic       stg_rdy [0:NSTG-1];
  tvdf_work_t stg_d   [0:NSTG-1];
  tvdf_work_t res;

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic       up_v;
    logic       dn_r;
    tvdf_work_t up_d;
    if (i == 0) begin : g_first
      assign up_v = in_valid;
      assign up_d = tvdf_entry(time_ms, time_valid);
    end else begin : g_mid
      assign up_v = stg_v[i-1];
      assign up_d = tvdf_stage(i, stg_d[i-1]);
    end
    if (i == NSTG - 1) begin : g_last
      assign dn_r = out_ready;
    end else begin : g_inner
      assign dn_r = stg_rdy[i+1];
    end
    tvdf_pipe_reg u_reg (
      .clk      (clk),
      .rst      (rst),
      .up_valid (up_v),
      .up_ready (stg_rdy[i]),
      .up_data  (up_d),
      .dn_valid (stg_v[i]),
      .dn_ready (dn_r),
      .dn_data  (stg_d[i])
    );
  end

  assign in_ready  = stg_rdy[0];
  assign out_valid = stg_v[NSTG-1];
  assign res       = stg_d[NSTG-1];

  assign fields_valid = res.ok;
  assign year         = res.ok ? res.year : '0;
  assign month        = res.ok ? res.month : '0;
  assign day_of_month = res.ok ? res.mday : '0;
  assign day_of_year  = res.ok ? res.doy : '0;
  assign leap_year    = res.ok && res.leap;
  assign weekday      = res.ok ? res.wday : '0;
  assign hour         = res.ok ? res.hour[4:0] : '0;
  assign minute       = res.ok ? res.minute : '0;
  assign second       = res.ok ? res.second : '0;
  assign millisecond  = res.ok ? res.rem_t[9:0] : '0;

  `TVDF_ASSERT_NEXT(a_enter, in_valid && in_ready, stg_v[0], "accepted item did not enter")
  `TVDF_ASSERT_NOW(a_range, out_valid && fields_valid, (month <= 4'd11) && (day_of_month != 5'd0) && (hour <= 5'd23) && (weekday <= 3'd6), "field out of range")
  `TVDF_ASSERT_NOW(a_leap, out_valid && fields_valid && !leap_year, day_of_year <= 9'd364, "day of year too large")
  `TVDF_ASSERT_NOW(a_zero, out_valid && !fields_valid, (year == 20'sd0) && (month == 4'd0) && (millisecond == 10'd0), "invalid result not cleared")
endmodule
